// ----- rtl/crc64b64_pkg.sv -----
// crc64b64_pkg: types, constants and helper functions for the crc-64/nvme base64 unit
// no dependencies; imported by every module under rtl

package crc64b64_pkg;

  localparam logic [63:0] CRC_INIT      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CRC_XOROUT    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CRC_POLY_REFL = 64'h9A6C_9329_AC4B_C9B5;
  localparam int          TEXT_LEN      = 12;
  localparam logic [3:0]  POS_PAD       = 4'd11;
  localparam logic [3:0]  POS_TAIL      = 4'd10;
  localparam logic [6:0]  PAD_CHAR      = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [6:0]  text_char;
    logic [3:0]  char_position;
    logic [63:0] checksum;
    logic        last_char;
  } out_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [63:0] crc_fold(logic [63:0] crc, logic [7:0] b);
    logic [63:0] r;
    r = crc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  // standard base64 alphabet
  function automatic logic [6:0] b64_char(logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

  // character at a text position of the big-endian digest
  function automatic logic [6:0] text_at(logic [63:0] d, logic [3:0] pos);
    logic [5:0] s;
    logic [6:0] c;
    s = 6'd0;
    case (pos)
      4'd0:    s = d[63:58];
      4'd1:    s = d[57:52];
      4'd2:    s = d[51:46];
      4'd3:    s = d[45:40];
      4'd4:    s = d[39:34];
      4'd5:    s = d[33:28];
      4'd6:    s = d[27:22];
      4'd7:    s = d[21:16];
      4'd8:    s = d[15:10];
      4'd9:    s = d[9:4];
      POS_TAIL: s = {d[3:0], 2'b00};
      default: s = 6'd0;
    endcase
    c = (pos == POS_PAD) ? PAD_CHAR : b64_char(s);
    return c;
  endfunction

endpackage

// ----- rtl/crc64_nvme_checksum_base64_unit.sv -----
// crc64_nvme_checksum_base64_unit: top level of the crc-64/nvme checksum with base64 text
// depends on crc64b64_pkg and crc64b64_emit

// Message bytes go in one per cycle while item_stall is low; each accepted
// byte is folded into the crc register in the same cycle. An item with
// end_of_message closes the message: its digest (after any byte it carries)
// leaves as 12 transactions, one base64 character each, positions 0 to 11,
// the last being '='. The characters go out one at a time through the single
// character output register; one further digest is held while the current one
// is sent, and the input is stalled only while that holding slot is occupied.

module crc64_nvme_checksum_base64_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  crc64b64_pkg::in_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output crc64b64_pkg::out_t result
);
  import crc64b64_pkg::*;

  logic [63:0] crc, crc_next;
  logic [63:0] folded;
  logic        accept;
  logic        space;
  logic        load;

  assign item_stall = !space;
  assign accept     = item_valid && !item_stall;
  assign folded     = item.byte_valid ? crc_fold(crc, item.data_byte) : crc;
  assign load       = accept && item.end_of_message;

  always_comb begin
    crc_next = crc;
    if (accept) begin
      crc_next = item.end_of_message ? CRC_INIT : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

  crc64b64_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_digest  (folded ^ CRC_XOROUT),
    .space        (space),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- rtl/crc64b64_emit.sv -----
// crc64b64_emit: holds finished digests and sends out the 12 text characters of each
// depends on crc64b64_pkg

module crc64b64_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [63:0]         load_digest,
  output logic                space,
  output logic                result_valid,
  input  logic                result_stall,
  output crc64b64_pkg::out_t  result
);
  import crc64b64_pkg::*;

  logic        out_valid, out_valid_next;
  logic [3:0]  out_pos, out_pos_next;
  logic [63:0] out_digest, out_digest_next;
  logic        pend_valid, pend_valid_next;
  logic [63:0] pend_digest, pend_digest_next;
  logic        take, finish, free;

  assign take   = out_valid && !result_stall;
  assign finish = take && (out_pos == POS_PAD);
  assign free   = !out_valid || finish;

  always_comb begin
    out_valid_next   = out_valid;
    out_pos_next     = out_pos;
    out_digest_next  = out_digest;
    pend_valid_next  = pend_valid;
    pend_digest_next = pend_digest;
    if (take && !finish) begin
      out_pos_next = out_pos + 4'd1;
    end
    if (free) begin
      out_pos_next = 4'd0;
      if (pend_valid) begin
        out_valid_next  = 1'b1;
        out_digest_next = pend_digest;
        pend_valid_next = 1'b0;
      end else if (load) begin
        out_valid_next  = 1'b1;
        out_digest_next = load_digest;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    // a load only arrives while the holding slot is empty
    if (load && !(free && !pend_valid)) begin
      pend_valid_next  = 1'b1;
      pend_digest_next = load_digest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_pos    <= 4'd0;
      pend_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      out_pos    <= out_pos_next;
      pend_valid <= pend_valid_next;
    end
    out_digest  <= out_digest_next;
    pend_digest <= pend_digest_next;
  end

  assign space        = !pend_valid;
  assign result_valid = out_valid;

  always_comb begin
    result.text_char     = text_at(out_digest, out_pos);
    result.char_position = out_pos;
    result.checksum      = out_digest;
    result.last_char     = (out_pos == POS_PAD);
  end

endmodule

// ----- rtl/crc64b64_checker.sv -----
// crc64b64_checker: port-level checks on the crc-64/nvme base64 unit, bound to the top level
// depends on crc64b64_pkg

module crc64b64_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input crc64b64_pkg::in_t  item,
  input logic               result_valid,
  input logic               result_stall,
  input crc64b64_pkg::out_t result
);
  import crc64b64_pkg::*;

  // characters of one digest follow in order and share the checksum
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_char |=>
      result_valid && result.char_position == $past(result.char_position) + 4'd1 &&
      $stable(result.checksum))
    else $error("text characters out of order");

  // pad place carries '=' and the last flag, and only there
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_char == (result.char_position == POS_PAD)) &&
      (!result.last_char || result.text_char == PAD_CHAR))
    else $error("pad place wrong");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.char_position <= POS_PAD)
    else $error("character position out of range");

  // an end transaction into an idle output starts a text at position 0
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.end_of_message && !result_valid |=>
      result_valid && result.char_position == 4'd0)
    else $error("digest text did not start");

endmodule

bind crc64_nvme_checksum_base64_unit crc64b64_checker u_checker (.*);

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for the crc-64/nvme unit with base64 text output
// depends on crc64b64_pkg and crc64_nvme_checksum_base64_unit; predicts each
// character transaction in the bench and checks every result against it
`timescale 1ns / 100ps

module tb_top;
  import crc64b64_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_t  item;
  logic result_valid;
  logic result_stall;
  out_t result;

  logic [63:0] crc_state;
  out_t        expected_chars[$];
  int          mismatch_count;
  int          cycle_count;
  int          bytes_sent;
  int          rx_wait;
  bit          tx_burst;
  bit          rx_burst;

  crc64_nvme_checksum_base64_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // reflected crc, one message bit at a time, lsb first
  function automatic logic [63:0] next_crc(logic [63:0] r, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY_REFL;
      end
    end
    return r;
  endfunction

  function automatic in_t make_item(logic [7:0] b, logic v, logic e);
    in_t it;
    it.data_byte      = b;
    it.byte_valid     = v;
    it.end_of_message = e;
    return it;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // fold the byte, and on end of message queue the twelve characters
  task automatic predict_accepted(in_t it);
    logic [63:0] digest;
    logic [5:0]  sextet;
    out_t        ch;
    if (it.byte_valid) begin
      crc_state = next_crc(crc_state, it.data_byte);
    end
    if (it.end_of_message) begin
      digest = crc_state ^ CRC_XOROUT;
      for (int k = 0; k < TEXT_LEN; k++) begin
        if (k < 10) begin
          sextet = 6'(digest >> (58 - 6 * k));
        end else begin
          sextet = {digest[3:0], 2'b00};
        end
        ch.text_char     = (k == TEXT_LEN - 1) ? PAD_CHAR
                                                : 7'(ALPHABET[8 * (63 - sextet) +: 8]);
        ch.char_position = 4'(k);
        ch.checksum      = digest;
        ch.last_char     = (k == TEXT_LEN - 1);
        expected_chars = {expected_chars, ch};
      end
      crc_state = CRC_INIT;
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (expected_chars.size() == 0) begin
      flag_mismatch($sformatf("unexpected result %p", got));
    end else begin
      want = expected_chars.pop_front();
      if (got.text_char !== want.text_char)
        flag_mismatch($sformatf("text_char %h, expected %h", got.text_char, want.text_char));
      if (got.char_position !== want.char_position)
        flag_mismatch($sformatf("char_position %0d, expected %0d",
                                got.char_position, want.char_position));
      if (got.checksum !== want.checksum)
        flag_mismatch($sformatf("checksum %h, expected %h", got.checksum, want.checksum));
      if (got.last_char !== want.last_char)
        flag_mismatch($sformatf("last_char %b, expected %b", got.last_char, want.last_char));
    end
  endtask

  // result side: check each transaction, then draw the stall before the next
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_result(result);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      result_stall <= 1'b1;
      rx_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_item(in_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    predict_accepted(it);
    if (it.byte_valid || it.end_of_message) begin
      bytes_sent++;
    end
  endtask

  task automatic send_noise();
    send_item(make_item(8'($urandom), 1'b0, 1'b0));
  endtask

  task automatic test_directed();
    logic [7:0] check_str[9] = '{"1", "2", "3", "4", "5", "6", "7", "8", "9"};
    // empty message
    send_item(make_item(8'h00, 1'b0, 1'b1));
    // standard check string, end riding on the last byte, one ignored transaction
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(check_str[i], 1'b1, 1'b0));
      if (i == 3) begin
        send_item(make_item(8'hA5, 1'b0, 1'b0));
      end
    end
    send_item(make_item(check_str[8], 1'b1, 1'b1));
    // byte extremes, end on its own
    send_item(make_item(8'h00, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'hFF, 1'b0, 1'b1));
    // back-to-back ends: first one is empty again, second carries one byte
    send_item(make_item(8'h5A, 1'b0, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b1));
  endtask

  task automatic test_random_messages(int target);
    int len;
    bit end_with_byte;
    while (bytes_sent < target) begin
      tx_burst = ($urandom_range(0, 5) == 0);
      rx_burst = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      end_with_byte = (len > 0) && $urandom_range(0, 1);
      for (int i = 0; i < len - int'(end_with_byte); i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_noise();
        end
        send_item(make_item(8'($urandom), 1'b1, 1'b0));
      end
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end
      send_item(make_item(8'($urandom), end_with_byte, 1'b1));
    end
  endtask

  // short messages with no gaps, so the digest holding slot fills up
  task automatic test_full_rate(int target);
    int len;
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    while (bytes_sent < target) begin
      if (bytes_sent > target - 35) begin
        rx_burst = 1'b0;
      end
      len = $urandom_range(0, 3);
      repeat (len) send_item(make_item(8'($urandom), 1'b1, 1'b0));
      send_item(make_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1));
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    result_stall   = 1'b0;
    crc_state      = CRC_INIT;
    mismatch_count = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    rx_wait        = 0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_messages(bytes_sent + 210);
    test_full_rate(bytes_sent + 70);

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- crc64_nvme_checksum_base64_unit.f -----
rtl/crc64b64_pkg.sv
rtl/crc64b64_emit.sv
rtl/crc64_nvme_checksum_base64_unit.sv
rtl/crc64b64_checker.sv
bench/tb_top.sv
